@@ rtl/core/msgfrag_pkg.sv @@
// Package with the shared types and constants of the message fragmenter.
`timescale 1ns / 1ps

package msgfrag_pkg;

   localparam int unsigned DIV_STEPS  = 32;
   localparam int unsigned STEP_WIDTH = $clog2(DIV_STEPS);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   localparam logic KIND_DESCRIPTOR = 1'b0;
   localparam logic KIND_BYTE       = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ROUND,
      ST_BYTE
   } state_type;

endpackage

@@ rtl/core/message_fragmenter.sv @@
// Message fragmenter: splits a byte stream into fragments with descriptors.
//
// A message-start transaction latches the length, clock and timestamp and, unless the
// configured payload size is zero, then keeps the block busy while a single
// subtract-and-compare unit works out the fragment count one quotient bit per cycle,
// followed by a rounding step. Payload bytes then pass at one per cycle, unless the
// output is held by back-pressure, through a single output register; a byte that
// opens a fragment sends its descriptor, then the byte itself, through that
// register one after the other. Bytes beyond the message length, and all bytes
// while the payload size latched at message start is zero, are taken and dropped.
`timescale 1ns / 1ps

module message_fragmenter #(
   parameter int unsigned HEADER_BYTES = 153
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_payload_per_fragment,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_message_length,
   input  logic [63:0] req_logical_clock,
   input  logic [63:0] req_time_stamp,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_fragment_index,
   output logic [31:0] rsp_fragment_count,
   output logic [16:0] rsp_fragment_bytes,
   output logic [63:0] rsp_out_clock,
   output logic [63:0] rsp_out_time_stamp,
   output logic [31:0] rsp_out_length,
   output logic        rsp_last
);

   localparam int unsigned SW = msgfrag_pkg::STEP_WIDTH;

   msgfrag_pkg::state_type state_ff, state_in;

   logic [15:0] payload_cfg_ff;
   logic [15:0] held_payload_ff;
   logic [31:0] bytes_left_ff;
   logic [31:0] current_fragment_ff;
   logic [15:0] offset_ff;
   logic [31:0] count_ff;
   logic [63:0] held_clock_ff;
   logic [63:0] held_time_stamp_ff;
   logic [31:0] held_length_ff;
   logic [15:0] frag_size_ff;
   logic [7:0]  pend_byte_ff;

   logic [31:0]   div_ff;
   logic [15:0]   rem_ff;
   logic [SW-1:0] step_ff;

   logic        rsp_valid_ff;
   logic        rsp_item_kind_ff;
   logic [7:0]  rsp_out_byte_ff;
   logic [31:0] rsp_fragment_index_ff;
   logic [31:0] rsp_fragment_count_ff;
   logic [16:0] rsp_fragment_bytes_ff;
   logic [63:0] rsp_out_clock_ff;
   logic [63:0] rsp_out_time_stamp_ff;
   logic [31:0] rsp_out_length_ff;
   logic        rsp_last_ff;

   logic        slot_free;
   logic        req_fire;
   logic        start_fire;
   logic        emit_desc;
   logic        emit_byte;
   logic [15:0] size_first;
   logic [15:0] size_cur;
   logic        last_now;
   logic [7:0]  byte_now;
   logic [16:0] trial;
   logic        trial_ge;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign size_first = (bytes_left_ff < {16'd0, held_payload_ff}) ?
                       bytes_left_ff[15:0] : held_payload_ff;
   assign size_cur   = (state_ff == msgfrag_pkg::ST_IDLE && offset_ff == 16'd0) ?
                       size_first : frag_size_ff;
   assign last_now   = ({1'b0, offset_ff} + 17'd1) == {1'b0, size_cur};
   assign byte_now   = (state_ff == msgfrag_pkg::ST_BYTE) ? pend_byte_ff : req_data_byte;

   assign trial    = {rem_ff, div_ff[31]};
   assign trial_ge = trial >= {1'b0, held_payload_ff};

   always_comb begin
      req_ready  = 1'b0;
      emit_desc  = 1'b0;
      emit_byte  = 1'b0;
      req_fire   = 1'b0;
      start_fire = 1'b0;
      unique case (state_ff)
         msgfrag_pkg::ST_IDLE: begin
            req_ready  = slot_free;
            req_fire   = req_valid && slot_free;
            start_fire = req_fire && req_type == msgfrag_pkg::REQ_START;
            if (req_fire && req_type == msgfrag_pkg::REQ_BYTE && bytes_left_ff != 32'd0) begin
               emit_desc = offset_ff == 16'd0;
               emit_byte = offset_ff != 16'd0;
            end
         end
         msgfrag_pkg::ST_BYTE: begin
            emit_byte = slot_free;
         end
         msgfrag_pkg::ST_DIVIDE, msgfrag_pkg::ST_ROUND: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msgfrag_pkg::ST_IDLE: begin
            if (start_fire && payload_cfg_ff != 16'd0) begin
               state_in = msgfrag_pkg::ST_DIVIDE;
            end else if (emit_desc) begin
               state_in = msgfrag_pkg::ST_BYTE;
            end
         end
         msgfrag_pkg::ST_DIVIDE: begin
            if (step_ff == SW'(msgfrag_pkg::DIV_STEPS - 1)) begin
               state_in = msgfrag_pkg::ST_ROUND;
            end
         end
         msgfrag_pkg::ST_ROUND: begin
            state_in = msgfrag_pkg::ST_IDLE;
         end
         msgfrag_pkg::ST_BYTE: begin
            if (slot_free) begin
               state_in = msgfrag_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msgfrag_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= msgfrag_pkg::ST_IDLE;
         payload_cfg_ff      <= 16'd0;
         held_payload_ff     <= 16'd0;
         bytes_left_ff       <= 32'd0;
         current_fragment_ff <= 32'd0;
         offset_ff           <= 16'd0;
         count_ff            <= 32'd0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            payload_cfg_ff <= csr_payload_per_fragment;
         end
         if (start_fire) begin
            held_payload_ff     <= payload_cfg_ff;
            current_fragment_ff <= 32'd0;
            offset_ff           <= 16'd0;
            count_ff            <= 32'd0;
            bytes_left_ff       <= (payload_cfg_ff == 16'd0) ? 32'd0 : req_message_length;
         end
         if (state_ff == msgfrag_pkg::ST_ROUND) begin
            count_ff <= div_ff + {31'd0, rem_ff != 16'd0};
         end
         if (emit_byte) begin
            bytes_left_ff <= bytes_left_ff - 32'd1;
            if (last_now) begin
               offset_ff           <= 16'd0;
               current_fragment_ff <= current_fragment_ff + 32'd1;
            end else begin
               offset_ff <= offset_ff + 16'd1;
            end
         end
         if (emit_desc || emit_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_fire) begin
         held_clock_ff      <= req_logical_clock;
         held_time_stamp_ff <= req_time_stamp;
         held_length_ff     <= req_message_length;
         div_ff             <= req_message_length;
         rem_ff             <= 16'd0;
         step_ff            <= '0;
      end else if (state_ff == msgfrag_pkg::ST_DIVIDE) begin
         div_ff  <= {div_ff[30:0], trial_ge};
         rem_ff  <= trial_ge ? 16'(trial - {1'b0, held_payload_ff}) : trial[15:0];
         step_ff <= step_ff + SW'(1);
      end
      if (emit_desc) begin
         frag_size_ff <= size_first;
         pend_byte_ff <= req_data_byte;
      end
      if (emit_desc || emit_byte) begin
         rsp_item_kind_ff      <= emit_byte ? msgfrag_pkg::KIND_BYTE
                                            : msgfrag_pkg::KIND_DESCRIPTOR;
         rsp_out_byte_ff       <= emit_byte ? byte_now : 8'd0;
         rsp_fragment_index_ff <= current_fragment_ff;
         rsp_fragment_count_ff <= count_ff;
         rsp_fragment_bytes_ff <= {1'b0, size_cur} + 17'(HEADER_BYTES);
         rsp_out_clock_ff      <= held_clock_ff;
         rsp_out_time_stamp_ff <= held_time_stamp_ff;
         rsp_out_length_ff     <= held_length_ff;
         rsp_last_ff           <= emit_byte && last_now;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item_kind      = rsp_item_kind_ff;
   assign rsp_out_byte       = rsp_out_byte_ff;
   assign rsp_fragment_index = rsp_fragment_index_ff;
   assign rsp_fragment_count = rsp_fragment_count_ff;
   assign rsp_fragment_bytes = rsp_fragment_bytes_ff;
   assign rsp_out_clock      = rsp_out_clock_ff;
   assign rsp_out_time_stamp = rsp_out_time_stamp_ff;
   assign rsp_out_length     = rsp_out_length_ff;
   assign rsp_last           = rsp_last_ff;

   // A descriptor is always followed by the byte that opened its fragment.
   a_desc_then_byte: assert property (@(posedge clock) disable iff (reset)
      emit_desc |=> state_ff == msgfrag_pkg::ST_BYTE)
      else $error("descriptor not followed by its byte");

   a_busy_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msgfrag_pkg::ST_DIVIDE || state_ff == msgfrag_pkg::ST_ROUND)
      |-> !req_ready)
      else $error("input taken while the fragment count is computed");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff != 16'd0 |-> offset_ff < frag_size_ff)
      else $error("offset beyond fragment size");

   a_bytes_need_payload: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff != 32'd0 |-> held_payload_ff != 16'd0)
      else $error("bytes pending with fragmentation disabled");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (emit_desc || emit_byte) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites a transaction not yet taken");

endmodule

@@ tb/message_fragmenter_checker.sv @@
// Checker that predicts the fragmenter's descriptors and payload bytes and compares them.
`timescale 1ns / 1ps

module message_fragmenter_checker #(
   parameter int unsigned HEADER_BYTES = 153
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_payload_per_fragment,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_message_length,
   input  logic [63:0] req_logical_clock,
   input  logic [63:0] req_time_stamp,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_item_kind,
   input  logic [7:0]  rsp_out_byte,
   input  logic [31:0] rsp_fragment_index,
   input  logic [31:0] rsp_fragment_count,
   input  logic [16:0] rsp_fragment_bytes,
   input  logic [63:0] rsp_out_clock,
   input  logic [63:0] rsp_out_time_stamp,
   input  logic [31:0] rsp_out_length,
   input  logic        rsp_last,

   output int          failures,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [31:0] index;
      logic [31:0] count;
      logic [16:0] size;
      logic [63:0] clk;
      logic [63:0] stamp;
      logic [31:0] length;
      logic        last;
   } fragment_item_type;

   logic [15:0] payload_setting;
   logic [15:0] held_payload;
   logic [15:0] frag_offset;
   logic [31:0] bytes_left;
   logic [31:0] frag_no;
   logic [31:0] frag_total;
   logic [31:0] held_length;
   logic [63:0] held_clock;
   logic [63:0] held_stamp;

   fragment_item_type fragment_items_due[$];

   function automatic fragment_item_type make_fragment_item(input logic kind,
                                                            input logic [7:0] data,
                                                            input logic [31:0] size,
                                                            input logic last);
      fragment_item_type item;
      item.kind   = kind;
      item.data   = data;
      item.index  = frag_no;
      item.count  = frag_total;
      item.size   = 17'(size + HEADER_BYTES);
      item.clk    = held_clock;
      item.stamp  = held_stamp;
      item.length = held_length;
      item.last   = last;
      return item;
   endfunction

   task automatic fragment_message_step(input logic kind, input logic [7:0] data,
                                        input logic [31:0] len, input logic [63:0] clk,
                                        input logic [63:0] stamp);
      logic [32:0] remaining;
      logic [31:0] size;
      logic        is_last;
      if (kind == msgfrag_pkg::REQ_START) begin
         held_clock   = clk;
         held_stamp   = stamp;
         held_length  = len;
         held_payload = payload_setting;
         frag_no      = 0;
         frag_offset  = 0;
         if (held_payload == 0) begin
            frag_total = 0;
            bytes_left = 0;
         end else begin
            frag_total = len / held_payload;
            if (len % held_payload != 0)
               frag_total = frag_total + 1;
            bytes_left = len;
         end
      end else if (held_payload != 0 && bytes_left != 0) begin
         remaining = {1'b0, bytes_left} + frag_offset;
         size = (remaining < held_payload) ? remaining[31:0] : {16'b0, held_payload};
         if (frag_offset == 0)
            fragment_items_due.push_back(
               make_fragment_item(msgfrag_pkg::KIND_DESCRIPTOR, 8'd0, size, 1'b0));
         is_last = ({16'b0, frag_offset} + 32'd1 == size);
         fragment_items_due.push_back(
            make_fragment_item(msgfrag_pkg::KIND_BYTE, data, size, is_last));
         bytes_left = bytes_left - 1;
         if (is_last) begin
            frag_offset = 0;
            frag_no     = frag_no + 1;
         end else begin
            frag_offset = frag_offset + 1;
         end
      end
   endtask

   function automatic int field_mismatch(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : monitor
      fragment_item_type want;
      int wrong;
      if (reset) begin
         payload_setting = 0;
         held_payload    = 0;
         frag_offset     = 0;
         bytes_left      = 0;
         frag_no         = 0;
         frag_total      = 0;
         held_length     = 0;
         held_clock      = 0;
         held_stamp      = 0;
         fragment_items_due.delete();
         failures = 0;
         checked  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (fragment_items_due.size() == 0) begin
               $error("Result transaction arrived with no result expected.");
               failures++;
            end else begin
               want  = fragment_items_due.pop_front();
               wrong = 0;
               wrong += field_mismatch("item_kind", want.kind, rsp_item_kind);
               wrong += field_mismatch("out_byte", want.data, rsp_out_byte);
               wrong += field_mismatch("fragment_index", want.index, rsp_fragment_index);
               wrong += field_mismatch("fragment_count", want.count, rsp_fragment_count);
               wrong += field_mismatch("fragment_bytes", want.size, rsp_fragment_bytes);
               wrong += field_mismatch("out_clock", want.clk, rsp_out_clock);
               wrong += field_mismatch("out_time_stamp", want.stamp, rsp_out_time_stamp);
               wrong += field_mismatch("out_length", want.length, rsp_out_length);
               wrong += field_mismatch("last", want.last, rsp_last);
               if (wrong != 0)
                  failures++;
               checked++;
            end
         end
         if (req_valid && req_ready)
            fragment_message_step(req_type, req_data_byte, req_message_length,
                                  req_logical_clock, req_time_stamp);
         if (csr_valid && csr_ready)
            payload_setting = csr_payload_per_fragment;
      end
      pending = fragment_items_due.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the fragmenter testbench: clock, reset, stimulus, back pressure and the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SETTLE_CYCLES = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_payload_per_fragment = 16'd0;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = msgfrag_pkg::REQ_START;
   logic [7:0]  req_data_byte = 8'd0;
   logic [31:0] req_message_length = 32'd0;
   logic [63:0] req_logical_clock = 64'd0;
   logic [63:0] req_time_stamp = 64'd0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_fragment_index;
   logic [31:0] rsp_fragment_count;
   logic [16:0] rsp_fragment_bytes;
   logic [63:0] rsp_out_clock;
   logic [63:0] rsp_out_time_stamp;
   logic [31:0] rsp_out_length;
   logic        rsp_last;

   int failures;
   int pending;
   int checked;

   int idle_odds = 4;
   int ready_hold = 0;
   int transactions_sent = 0;
   int messages_sent = 0;
   int settings_used = 0;

   always #5 clock = ~clock;

   message_fragmenter u_top (
      .clock                    (clock),
      .reset                    (reset),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_payload_per_fragment (csr_payload_per_fragment),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_type                 (req_type),
      .req_data_byte            (req_data_byte),
      .req_message_length       (req_message_length),
      .req_logical_clock        (req_logical_clock),
      .req_time_stamp           (req_time_stamp),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_item_kind            (rsp_item_kind),
      .rsp_out_byte             (rsp_out_byte),
      .rsp_fragment_index       (rsp_fragment_index),
      .rsp_fragment_count       (rsp_fragment_count),
      .rsp_fragment_bytes       (rsp_fragment_bytes),
      .rsp_out_clock            (rsp_out_clock),
      .rsp_out_time_stamp       (rsp_out_time_stamp),
      .rsp_out_length           (rsp_out_length),
      .rsp_last                 (rsp_last)
   );

   message_fragmenter_checker u_checker (
      .clock                    (clock),
      .reset                    (reset),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_payload_per_fragment (csr_payload_per_fragment),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_type                 (req_type),
      .req_data_byte            (req_data_byte),
      .req_message_length       (req_message_length),
      .req_logical_clock        (req_logical_clock),
      .req_time_stamp           (req_time_stamp),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_item_kind            (rsp_item_kind),
      .rsp_out_byte             (rsp_out_byte),
      .rsp_fragment_index       (rsp_fragment_index),
      .rsp_fragment_count       (rsp_fragment_count),
      .rsp_fragment_bytes       (rsp_fragment_bytes),
      .rsp_out_clock            (rsp_out_clock),
      .rsp_out_time_stamp       (rsp_out_time_stamp),
      .rsp_out_length           (rsp_out_length),
      .rsp_last                 (rsp_last),
      .failures                 (failures),
      .pending                  (pending),
      .checked                  (checked)
   );

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         ready_hold <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #3_000_000;
      $display("testbench failed");
      $finish;
   end

   task automatic offer_transaction(input logic kind, input logic [7:0] data,
                                    input logic [31:0] len, input logic [63:0] clk,
                                    input logic [63:0] stamp);
      if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_data_byte      <= data;
      req_message_length <= len;
      req_logical_clock  <= clk;
      req_time_stamp     <= stamp;
      do @(posedge clock); while (!req_ready);
      transactions_sent++;
      if (kind == msgfrag_pkg::REQ_START)
         messages_sent++;
   endtask

   task automatic start_message(input logic [31:0] len);
      offer_transaction(msgfrag_pkg::REQ_START, 8'($urandom), len, {$urandom, $urandom},
                        {$urandom, $urandom});
   endtask

   task automatic send_bytes(input int n);
      repeat (n)
         offer_transaction(msgfrag_pkg::REQ_BYTE, 8'($urandom), $urandom,
                           {$urandom, $urandom}, {$urandom, $urandom});
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_payload_size(input logic [15:0] value);
      csr_valid                <= 1'b1;
      csr_payload_per_fragment <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_message(input int payload);
      int choice;
      int cap;
      int len;
      choice = $urandom_range(0, 9);
      cap = (payload == 0) ? 12 : ((3 * payload < 40) ? 3 * payload : 40);
      len = $urandom_range(1, cap);
      if (choice < 6) begin
         start_message(len);
         send_bytes(len);
      end else if (choice == 6) begin
         start_message(($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
         send_bytes($urandom_range(1, 3));
      end else if (choice == 7) begin
         start_message(len);
         send_bytes($urandom_range(0, len - 1));
      end else if (choice == 8) begin
         start_message($urandom);
         send_bytes($urandom_range(1, 4));
      end else begin
         start_message(len);
         send_bytes(len + $urandom_range(1, 3));
      end
   endtask

   initial begin
      logic [15:0] sizes[10];
      int budget;
      int first;
      sizes = '{16'd1, 16'd2, 16'd3, 16'd7, 16'd16, 16'hFFFF, 16'($urandom), 16'd0,
                16'd5, 16'($urandom)};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any message, then a message while fragmentation is disabled.
      offer_transaction(msgfrag_pkg::REQ_BYTE, 8'h00, 32'd0, 64'd0, 64'd0);
      offer_transaction(msgfrag_pkg::REQ_START, 8'h00, 32'd5, 64'd0, 64'd0);
      offer_transaction(msgfrag_pkg::REQ_BYTE, 8'hFF, 32'hFFFF_FFFF, '1, '1);
      settle();
      write_payload_size(16'd3);
      // An empty message drops its bytes; a short one ends with an excess byte.
      offer_transaction(msgfrag_pkg::REQ_START, 8'hFF, 32'd0, '1, '1);
      offer_transaction(msgfrag_pkg::REQ_BYTE, 8'hA5, 32'd0, 64'd0, 64'd0);
      offer_transaction(msgfrag_pkg::REQ_START, 8'h00, 32'd4, 64'h0123_4567_89AB_CDEF,
                        64'hFEDC_BA98_7654_3210);
      offer_transaction(msgfrag_pkg::REQ_BYTE, 8'h00, 32'd0, 64'd0, 64'd0);
      offer_transaction(msgfrag_pkg::REQ_BYTE, 8'hFF, 32'd0, 64'd0, 64'd0);
      send_bytes(3);
      // A new payload size written mid-message waits for the next message start.
      start_message(32'd10);
      send_bytes(4);
      settle();
      write_payload_size(16'hFFFF);
      send_bytes(6);
      settle();
      write_payload_size(16'd1);
      offer_transaction(msgfrag_pkg::REQ_START, 8'h00, 32'hFFFF_FFFF, '1, 64'd0);
      send_bytes(1);
      settle();
      write_payload_size(16'hFFFF);
      offer_transaction(msgfrag_pkg::REQ_START, 8'h00, 32'hFFFF_FFFF, 64'd0, '1);
      send_bytes(2);

      foreach (sizes[i]) begin
         settle();
         idle_odds = (i == 9) ? 0 : ((i % 3 == 2) ? 0 : ((i % 3 == 0) ? 3 : 8));
         write_payload_size(sizes[i]);
         budget = (sizes[i] == 0) ? 20 : 56;
         first = transactions_sent;
         while (transactions_sent - first < budget)
            random_message(sizes[i]);
      end
      settle();

      $display("Sent %0d transactions in %0d messages under %0d payload size settings.",
               transactions_sent, messages_sent, settings_used);
      $display("Compared %0d descriptor and payload byte results with the prediction.",
               checked);
      if (failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
